// File: rtl/salc_pkg.sv
`timescale 1ns / 1ps
// salc_pkg: shared constants, command and register codes and types for the
// set-associative lru cache model. no dependencies.
package salc_pkg;

   localparam int DEF_MAX_SET_BITS = 5;
   localparam int DEF_MAX_WAYS     = 8;

   localparam int ADDR_W     = 64;
   localparam int CMD_W      = 2;
   localparam int TOTAL_W    = 32;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_PAD_W  = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // access commands
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_IGNORE = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [5:0] block_bits;
      logic [3:0] ways;
   } cfg_type;

   typedef struct packed {
      logic access;
      logic modify;
   } job_ctrl_type;

   typedef enum logic {
      BK_IDLE,
      BK_LOOKUP
   } back_state_type;

endpackage

// File: rtl/salc_ram.sv
`timescale 1ns / 1ps
// salc_ram: generic single-write, single-read ram with registered read data.
// no dependencies.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/salc_front.sv
`timescale 1ns / 1ps
// salc_front: takes access items, splits the address into set and tag and
// keeps them in a two-entry queue for the back end. uses salc_pkg.
module salc_front #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  salc_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [salc_pkg::ADDR_W-1:0]   req_tdata,  // address
   input  logic [salc_pkg::CMD_W-1:0]    req_tuser,  // cmd
   output logic                          q_valid,
   input  logic                          q_pop,
   output salc_pkg::job_ctrl_type        q_ctrl,
   output logic [SET_W-1:0]              q_set,
   output logic [salc_pkg::ADDR_W-1:0]   q_tag
);
   import salc_pkg::*;

   localparam int QD = 2;

   job_ctrl_type      ctrl_ff [QD];
   logic [SET_W-1:0]  set_ff  [QD];
   logic [ADDR_W-1:0] tag_ff  [QD];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   logic              push;
   logic [2:0]        sb_act;
   logic [ADDR_W-1:0] shifted;
   logic [ADDR_W-1:0] set_mask;
   logic [ADDR_W-1:0] set_full;
   logic [6:0]        tag_shamt;
   logic [ADDR_W-1:0] tag_val;
   job_ctrl_type      ctrl_val;

   // address split
   always_comb begin
      if (int'(cfg.set_bits) > MAX_SET_BITS) begin
         sb_act = 3'(MAX_SET_BITS);
      end else begin
         sb_act = cfg.set_bits;
      end
      shifted   = req_tdata >> cfg.block_bits;
      set_mask  = (ADDR_W'(1) << sb_act) - ADDR_W'(1);
      set_full  = shifted & set_mask;
      tag_shamt = 7'(cfg.block_bits) + 7'(sb_act);
      // offset plus index reaching 64 leaves no tag bits
      if (tag_shamt[6]) begin
         tag_val = '0;
      end else begin
         tag_val = req_tdata >> tag_shamt[5:0];
      end
      ctrl_val.access = (req_tuser != CMD_IGNORE);
      ctrl_val.modify = (req_tuser == CMD_MODIFY);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_ctrl     = ctrl_ff[rd_ptr_ff];
   assign q_set      = set_ff[rd_ptr_ff];
   assign q_tag      = tag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff] <= ctrl_val;
         set_ff[wr_ptr_ff]  <= set_full[SET_W-1:0];
         tag_ff[wr_ptr_ff]  <= tag_val;
      end
   end

endmodule

// File: rtl/salc_back.sv
`timescale 1ns / 1ps
// salc_back: reads a set, looks up the tag, fills or evicts, updates the lru
// order and totals and holds the result item. uses salc_pkg and salc_ram.
module salc_back #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  salc_pkg::cfg_type                 cfg,
   input  logic                              flush,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  salc_pkg::job_ctrl_type            q_ctrl,
   input  logic [SET_W-1:0]                  q_set,
   input  logic [salc_pkg::ADDR_W-1:0]       q_tag,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [salc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import salc_pkg::*;

   localparam int SETS  = 2 ** MAX_SET_BITS;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam int ROW_W = MAX_WAYS * WAY_W;

   typedef logic [MAX_WAYS-1:0][WAY_W-1:0] order_type;

   back_state_type     state_ff, state_in;
   job_ctrl_type       cur_ctrl_ff, cur_ctrl_in;
   logic [SET_W-1:0]   cur_set_ff, cur_set_in;
   logic [ADDR_W-1:0]  cur_tag_ff, cur_tag_in;
   logic [MAX_WAYS-1:0] line_valid_ff [SETS];
   logic [SETS-1:0]    lru_valid_ff;
   logic [TOTAL_W-1:0] hit_count_ff, hit_count_in;
   logic [TOTAL_W-1:0] miss_count_ff, miss_count_in;
   logic [TOTAL_W-1:0] evict_count_ff, evict_count_in;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               rd_en;
   logic               do_update;
   logic [ADDR_W-1:0]  tag_q [MAX_WAYS];
   logic [ROW_W-1:0]   lru_q;
   order_type          ident;
   order_type          order;
   order_type          new_order;
   logic [CNT_W-1:0]   n_act;
   logic [MAX_WAYS-1:0] valid_row;
   logic [MAX_WAYS-1:0] hit_vec;
   logic [MAX_WAYS-1:0] inv_vec;
   logic               any_hit;
   logic               any_inv;
   logic [WAY_W-1:0]   hit_way;
   logic [WAY_W-1:0]   inv_way;
   logic [WAY_W-1:0]   touch;
   logic [WAY_W-1:0]   pos;
   logic               pos_found;
   logic [1:0]         item_hits;
   logic               item_miss;
   logic               item_evict;
   logic               tag_we;
   logic               lru_we;

   // tag store, one ram per way
   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      salc_ram #(.WIDTH(ADDR_W), .DEPTH(SETS)) u_tag_ram (
         .clock   (clock),
         .wr_en   (tag_we && (touch == WAY_W'(w))),
         .wr_addr (cur_set_ff),
         .wr_data (cur_tag_ff),
         .rd_en   (rd_en),
         .rd_addr (q_set),
         .rd_data (tag_q[w])
      );
      assign ident[w] = WAY_W'(w);
   end

   salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_lru_ram (
      .clock   (clock),
      .wr_en   (lru_we),
      .wr_addr (cur_set_ff),
      .wr_data (new_order),
      .rd_en   (rd_en),
      .rd_addr (q_set),
      .rd_data (lru_q)
   );

   always_comb begin
      if (cfg.ways == 4'd0) begin
         n_act = CNT_W'(1);
      end else if (int'(cfg.ways) > MAX_WAYS) begin
         n_act = CNT_W'(MAX_WAYS);
      end else begin
         n_act = CNT_W'(cfg.ways);
      end
   end

   // lookup, victim choice and lru reorder
   always_comb begin
      valid_row = line_valid_ff[cur_set_ff];
      // an unwritten row is taken as the identity order
      order     = lru_valid_ff[cur_set_ff] ? order_type'(lru_q) : ident;
      any_hit   = 1'b0;
      any_inv   = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         hit_vec[i] = (CNT_W'(i) < n_act) && valid_row[i] && (tag_q[i] == cur_tag_ff);
         inv_vec[i] = (CNT_W'(i) < n_act) && !valid_row[i];
         if (hit_vec[i]) begin
            any_hit = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (inv_vec[i]) begin
            any_inv = 1'b1;
            inv_way = WAY_W'(i);
         end
      end
      if (any_hit) begin
         touch = hit_way;
      end else if (any_inv) begin
         touch = inv_way;
      end else begin
         touch = order[0];
      end
      pos       = '0;
      pos_found = 1'b0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (!pos_found && (CNT_W'(i) < n_act) && (order[i] == touch)) begin
            pos       = WAY_W'(i);
            pos_found = 1'b1;
         end
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         if ((CNT_W'(i) >= n_act) || (CNT_W'(i) < CNT_W'(pos))) begin
            new_order[i] = order[i];
         end else if (CNT_W'(i) == n_act - CNT_W'(1)) begin
            new_order[i] = touch;
         end else if (i < MAX_WAYS - 1) begin
            new_order[i] = order[(i < MAX_WAYS - 1) ? i + 1 : i];
         end else begin
            new_order[i] = touch;
         end
      end
      // a modify's second access hits the line just touched
      if (cur_ctrl_ff.access) begin
         item_hits  = 2'(any_hit) + 2'(cur_ctrl_ff.modify);
         item_miss  = !any_hit;
         item_evict = !any_hit && !any_inv;
      end else begin
         item_hits  = 2'd0;
         item_miss  = 1'b0;
         item_evict = 1'b0;
      end
      tag_we = do_update && cur_ctrl_ff.access && !any_hit;
      lru_we = do_update && cur_ctrl_ff.access;
      hit_count_in   = hit_count_ff + TOTAL_W'(item_hits);
      miss_count_in  = miss_count_ff + TOTAL_W'(item_miss);
      evict_count_in = evict_count_ff + TOTAL_W'(item_evict);
      rsp_data_in = {RSP_PAD_W'(0), evict_count_in, miss_count_in, hit_count_in,
                     item_evict, item_miss, item_hits};
   end

   // sequencer: read the set, then resolve and write back
   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      rd_en       = 1'b0;
      do_update   = 1'b0;
      cur_ctrl_in = cur_ctrl_ff;
      cur_set_in  = cur_set_ff;
      cur_tag_in  = cur_tag_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_tready)) begin
               q_pop       = 1'b1;
               rd_en       = 1'b1;
               cur_ctrl_in = q_ctrl;
               cur_set_in  = q_set;
               cur_tag_in  = q_tag;
               state_in    = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            do_update = 1'b1;
            state_in  = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         rsp_valid_ff   <= 1'b0;
         hit_count_ff   <= '0;
         miss_count_ff  <= '0;
         evict_count_ff <= '0;
         lru_valid_ff   <= '0;
         for (int s = 0; s < SETS; s++) begin
            line_valid_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (flush) begin
            lru_valid_ff <= '0;
            for (int s = 0; s < SETS; s++) begin
               line_valid_ff[s] <= '0;
            end
         end else if (lru_we) begin
            lru_valid_ff[cur_set_ff]         <= 1'b1;
            line_valid_ff[cur_set_ff][touch] <= 1'b1;
         end
         if (do_update) begin
            hit_count_ff   <= hit_count_in;
            miss_count_ff  <= miss_count_in;
            evict_count_ff <= evict_count_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ctrl_ff <= cur_ctrl_in;
      cur_set_ff  <= cur_set_in;
      cur_tag_ff  <= cur_tag_in;
      if (do_update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/set_assoc_lru_cache_sim.sv
`timescale 1ns / 1ps
// set_assoc_lru_cache_sim: top level with register port, front end queue and
// back end lookup. uses salc_pkg, salc_front, salc_back (and salc_ram).
//
//   channel   dir   handshake              payload
//   req_      in    tvalid / tready        tuser: cmd; tdata: address
//   rsp_      out   tvalid / tready        tdata: hits, miss, evict, totals
//   csr_      in    psel / penable         set_bits, block_bits, ways
//
// in the back end every item first reads the set's tags and lru row from ram,
// then compares, picks the way and writes back.
// a two-entry queue in the front keeps taking items while it has room and the back works.
// synchronous reset clears valid bits at once; there is no clearing pass.
// the back end waits only when the result register is full and not taken.
module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [salc_pkg::ADDR_W-1:0]       req_tdata,   // [63:0] address
   input  logic [salc_pkg::CMD_W-1:0]        req_tuser,   // [1:0] cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] item_hits, [2] item_miss, [3] item_evict, [35:4] hit_total,
   // [67:36] miss_total, [99:68] evict_total, [103:100] zero
   output logic [salc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import salc_pkg::*;

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   cfg_type           cfg_ff, cfg_in;
   logic              csr_wr;
   logic              flush;
   logic              q_valid;
   logic              q_pop;
   job_ctrl_type      q_ctrl;
   logic [SET_W-1:0]  q_set;
   logic [ADDR_W-1:0] q_tag;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      flush  = 1'b0;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_SET_BITS: begin
               cfg_in.set_bits = csr_pwdata[2:0];
               flush           = 1'b1;
            end
            CSR_BLOCK_BITS: begin
               cfg_in.block_bits = csr_pwdata[5:0];
               flush             = 1'b1;
            end
            CSR_WAYS: begin
               cfg_in.ways = csr_pwdata[3:0];
               flush       = 1'b1;
            end
            default: begin
               flush = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_SET_BITS:   csr_prdata = CSR_DATA_W'(cfg_ff.set_bits);
         CSR_BLOCK_BITS: csr_prdata = CSR_DATA_W'(cfg_ff.block_bits);
         CSR_WAYS:       csr_prdata = CSR_DATA_W'(cfg_ff.ways);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits   <= 3'd0;
         cfg_ff.block_bits <= 6'd0;
         cfg_ff.ways       <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctrl     (q_ctrl),
      .q_set      (q_set),
      .q_tag      (q_tag)
   );

   salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .flush      (flush),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_ctrl     (q_ctrl),
      .q_set      (q_set),
      .q_tag      (q_tag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
